// ----- sv/rfpp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and defaults for the rotated framebuffer pixel plotter.
// No dependencies; every other file of the block imports this package.
package rfpp_pkg;

   localparam int unsigned PHYS_WIDTH_DEF  = 792;
   localparam int unsigned PHYS_HEIGHT_DEF = 528;

   localparam int unsigned CFG_W    = 10;
   localparam int unsigned COORD_W  = 12;
   localparam int unsigned FUNC_W   = 3;
   localparam int unsigned PAT_W    = 2;
   localparam int unsigned BADDR_W  = 16;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned APB_DW   = 32;
   localparam int unsigned APB_AW   = 3;

   localparam logic [CFG_W-1:0] LOGICAL_WIDTH_RST  = 10'd528;
   localparam logic [CFG_W-1:0] LOGICAL_HEIGHT_RST = 10'd792;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_BLACK  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_WHITE  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INVERT = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RDBYTE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_WRBYTE = 3'd4;

   // Register indexes, taken from paddr[2].
   localparam logic REG_LWIDTH  = 1'b0;
   localparam logic REG_LHEIGHT = 1'b1;

   localparam logic [BYTE_W-1:0] PIXEL_MSB = 8'h80;

   typedef struct packed {
      logic [CFG_W-1:0] logical_width;
      logic [CFG_W-1:0] logical_height;
   } cfg_type;

endpackage

// ----- sv/rfpp_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for operation requests and their responses.
// Depends on rfpp_pkg for field widths.
interface rfpp_req_if;
   import rfpp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic [PAT_W-1:0]          pattern;
   logic [BADDR_W-1:0]        byte_address;
   logic [BYTE_W-1:0]         write_data;

   modport source (output valid, func, pos_x, pos_y, pattern, byte_address, write_data,
                   input ready);
   modport sink (input valid, func, pos_x, pos_y, pattern, byte_address, write_data,
                 output ready);
endinterface

interface rfpp_rsp_if;
   import rfpp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_data;
   logic              applied;

   modport source (output valid, read_data, applied, input ready);
   modport sink (input valid, read_data, applied, output ready);
endinterface

// ----- sv/rotated_framebuffer_pixel_plotter.sv -----
`timescale 1ns / 1ps
// Top level of the rotated 1-bit framebuffer pixel plotter.
// Depends on rfpp_pkg, rfpp_if, rfpp_csr and rfpp_store.
//
//   Channel   Direction  Handshake        Carries
//   req_chan  in         valid/ready      func, pos_x, pos_y, pattern, byte_address, write_data
//   rsp_chan  out        valid/ready      read_data, applied
//   APB       in         psel/penable     logical_width (0x0), logical_height (0x4)
//
//   One operation is in flight at a time and passes in turn through the transfer, the
// address calculation, the memory read and the modify/write-back that loads the
// result register. The store's registered read gives the memory read a step of its own.
// A new request is taken as soon as the previous result is loaded, even while it
// still waits on rsp_chan.ready; a stalled result holds the block in the write-back step.
// Synchronous active-high reset clears the control state and restores the clip
// registers; the framebuffer contents are undefined until software writes them.
module rotated_framebuffer_pixel_plotter #(
   parameter int unsigned PHYS_WIDTH  = rfpp_pkg::PHYS_WIDTH_DEF,
   parameter int unsigned PHYS_HEIGHT = rfpp_pkg::PHYS_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   rfpp_req_if.sink                    req_chan,
   rfpp_rsp_if.source                  rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rfpp_pkg::APB_AW-1:0] paddr,
   input  logic [rfpp_pkg::APB_DW-1:0] pwdata,
   output logic [rfpp_pkg::APB_DW-1:0] prdata,
   output logic                        pready
);
   import rfpp_pkg::*;

   localparam int unsigned ROW_BYTES = (PHYS_WIDTH + 7) / 8;
   localparam int unsigned DEPTH     = ROW_BYTES * PHYS_HEIGHT;
   localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CALC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_MOD  = 2'd3;

   cfg_type cfg;

   rfpp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic [1:0]                state_ff, state_in;
   logic [FUNC_W-1:0]         func_ff;
   logic signed [COORD_W-1:0] x_ff;
   logic signed [COORD_W-1:0] y_ff;
   logic [PAT_W-1:0]          pattern_ff;
   logic [BADDR_W-1:0]        baddr_ff;
   logic [BYTE_W-1:0]         wdata_ff;
   logic                      hit_ff;
   logic [AW-1:0]             addr_ff;
   logic [BYTE_W-1:0]         mask_ff;
   logic                      rsp_valid_ff;
   logic [BYTE_W-1:0]         rsp_data_ff;
   logic                      rsp_applied_ff;

   logic                      req_xfer;
   logic                      out_free;
   logic                      pix_op;
   logic                      pat_pass;
   logic                      pix_hit;
   logic                      byte_hit;
   logic [31:0]               x_u;
   logic [31:0]               y_u;
   logic [31:0]               py;
   logic [31:0]               pix_idx;
   logic [31:0]               byte_idx;
   logic [BYTE_W-1:0]         mem_rd_data;
   logic [BYTE_W-1:0]         new_byte;
   logic                      mem_we;
   logic                      load_rsp;

   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Clipping, dither gating and rotation into a byte index.
   assign pix_op   = (func_ff == FUNC_BLACK) || (func_ff == FUNC_WHITE)
                     || (func_ff == FUNC_INVERT);
   assign pat_pass = !(pattern_ff[0] && (x_ff[0] ^ y_ff[0]))
                     && !(pattern_ff[1] && (x_ff[0] | y_ff[0]));
   assign x_u      = {21'd0, x_ff[COORD_W-2:0]};
   assign y_u      = {21'd0, y_ff[COORD_W-2:0]};
   assign pix_hit  = pat_pass && !x_ff[COORD_W-1] && !y_ff[COORD_W-1]
                     && (x_u < {22'd0, cfg.logical_width})
                     && (y_u < {22'd0, cfg.logical_height})
                     && (x_u < 32'(PHYS_HEIGHT)) && (y_u < 32'(PHYS_WIDTH));
   assign py       = 32'(PHYS_HEIGHT - 1) - x_u;
   assign pix_idx  = py * 32'(ROW_BYTES) + (y_u >> 3);
   assign byte_idx = {16'd0, baddr_ff};
   assign byte_hit = ((func_ff == FUNC_RDBYTE) || (func_ff == FUNC_WRBYTE))
                     && (byte_idx < 32'(DEPTH));

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff    <= req_chan.func;
         x_ff       <= req_chan.pos_x;
         y_ff       <= req_chan.pos_y;
         pattern_ff <= req_chan.pattern;
         baddr_ff   <= req_chan.byte_address;
         wdata_ff   <= req_chan.write_data;
      end
      if (state_ff == S_CALC) begin
         hit_ff  <= pix_op ? pix_hit : byte_hit;
         addr_ff <= pix_op ? pix_idx[AW-1:0] : byte_idx[AW-1:0];
         mask_ff <= PIXEL_MSB >> y_ff[2:0];
      end
   end

   rfpp_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (state_ff == S_READ),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_we),
      .wr_addr (addr_ff),
      .wr_data (new_byte)
   );

   always_comb begin
      case (func_ff)
         FUNC_BLACK:  new_byte = mem_rd_data & ~mask_ff;
         FUNC_WHITE:  new_byte = mem_rd_data | mask_ff;
         FUNC_INVERT: new_byte = mem_rd_data ^ mask_ff;
         FUNC_WRBYTE: new_byte = wdata_ff;
         default:     new_byte = mem_rd_data;
      endcase
   end

   // The write-back happens in the same cycle the result register is loaded.
   assign load_rsp = (state_ff == S_MOD) && out_free;
   assign mem_we   = load_rsp && hit_ff && (func_ff != FUNC_RDBYTE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_xfer) state_in = S_CALC;
         S_CALC:  state_in = S_READ;
         S_READ:  state_in = S_MOD;
         S_MOD:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff    <= hit_ff ? new_byte : '0;
         rsp_applied_ff <= hit_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.applied   = rsp_applied_ff;

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_chan.ready)
      else $error("request taken while an operation is in flight");

   a_reaches_modify: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> ##3 (state_ff == S_MOD))
      else $error("operation did not reach write-back three cycles after its transfer");

   a_skip_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.applied) |-> (rsp_chan.read_data == '0))
      else $error("skipped operation returned nonzero data");

   a_write_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (hit_ff && !rsp_valid_ff) || (hit_ff && rsp_chan.ready))
      else $error("store written without a result slot or without a hit");
`endif

endmodule

// ----- sv/rfpp_csr.sv -----
`timescale 1ns / 1ps
// APB-style register file holding the logical clip width and height.
// Depends on rfpp_pkg for cfg_type and the register indexes.
module rfpp_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [rfpp_pkg::APB_AW-1:0] paddr,
   input  logic [rfpp_pkg::APB_DW-1:0] pwdata,
   output logic [rfpp_pkg::APB_DW-1:0] prdata,
   output logic                      pready,
   output rfpp_pkg::cfg_type         cfg
);
   import rfpp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_LWIDTH:  cfg_in.logical_width  = pwdata[CFG_W-1:0];
            REG_LHEIGHT: cfg_in.logical_height = pwdata[CFG_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.logical_width  <= LOGICAL_WIDTH_RST;
         cfg_ff.logical_height <= LOGICAL_HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LWIDTH:  prdata = {(APB_DW-CFG_W)'(0), cfg_ff.logical_width};
         REG_LHEIGHT: prdata = {(APB_DW-CFG_W)'(0), cfg_ff.logical_height};
         default:     prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/rfpp_store.sv -----
`timescale 1ns / 1ps
// Single-port-write, registered-read byte memory holding the framebuffer.
// Depends on rfpp_pkg for the byte width.
module rfpp_store #(
   parameter int unsigned DEPTH = 52272,
   parameter int unsigned AW    = 16
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [rfpp_pkg::BYTE_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [rfpp_pkg::BYTE_W-1:0] wr_data
);
   import rfpp_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the rotated framebuffer pixel plotter.
// Depends on rfpp_pkg, rfpp_if and the rotated_framebuffer_pixel_plotter top level.
module tb;
   import rfpp_pkg::*;

   localparam int unsigned PHYS_WIDTH  = PHYS_WIDTH_DEF;
   localparam int unsigned PHYS_HEIGHT = PHYS_HEIGHT_DEF;
   localparam int unsigned ROW_BYTES   = (PHYS_WIDTH + 7) / 8;
   localparam int unsigned STORE_DEPTH = ROW_BYTES * PHYS_HEIGHT;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

   localparam logic [PAT_W-1:0] PAT_NONE    = 2'd0;
   localparam logic [PAT_W-1:0] PAT_CHECKER = 2'd1;
   localparam logic [PAT_W-1:0] PAT_QUARTER = 2'd2;
   localparam logic [PAT_W-1:0] PAT_BOTH    = 2'd3;

   localparam logic [CFG_W-1:0] CLIP_MAX = 10'd1023;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [PAT_W-1:0]   pattern;
      logic [BADDR_W-1:0] byte_address;
      logic [BYTE_W-1:0]  write_data;
   } plot_op_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              applied;
   } plot_result_type;

   logic clock;
   logic reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [APB_AW-1:0] paddr;
   logic [APB_DW-1:0] pwdata;
   logic [APB_DW-1:0] prdata;
   logic              pready;

   rfpp_req_if req_chan ();
   rfpp_rsp_if rsp_chan ();

   rotated_framebuffer_pixel_plotter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Shadow of the framebuffer and the clip registers.
   logic [BYTE_W-1:0] frame_copy [0:STORE_DEPTH-1];
   // The store holds garbage after reset, so a byte is written before it is first read.
   bit written [0:STORE_DEPTH-1];
   int clip_width;
   int clip_height;

   plot_result_type awaited_results[$];
   plot_result_type front_result;
   int fail_count;
   int cycle_count;
   int stall_left;
   bit idle_enable;
   int win_x;
   int win_y;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int idle_gap();
      int roll;
      if (!idle_enable) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Result sink: random back-pressure on the response channel.
   initial begin
      rsp_chan.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            stall_left = idle_gap();
            rsp_chan.ready <= (stall_left == 0);
         end
      end
   end

   // Every response transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: response with nothing outstanding, read_data %h applied %b",
                     $time, rsp_chan.read_data, rsp_chan.applied);
            fail_count++;
         end else begin
            front_result = awaited_results.pop_front();
            if (rsp_chan.read_data !== front_result.read_data) begin
               $display("%0t: read_data mismatch, expected %h, got %h",
                        $time, front_result.read_data, rsp_chan.read_data);
               fail_count++;
            end
            if (rsp_chan.applied !== front_result.applied) begin
               $display("%0t: applied mismatch, expected %b, got %b",
                        $time, front_result.applied, rsp_chan.applied);
               fail_count++;
            end
         end
      end
   end

   function automatic plot_result_type framebuffer_result(plot_op_type op);
      plot_result_type res;
      int x;
      int y;
      int unsigned idx;
      logic [BYTE_W-1:0] mask;
      logic [BYTE_W-1:0] cur;
      logic gated;
      res = '0;
      x = $signed(op.pos_x);
      y = $signed(op.pos_y);
      if (op.func == FUNC_BLACK || op.func == FUNC_WHITE || op.func == FUNC_INVERT) begin
         // Parity comes from the raw two's complement low bits.
         gated = (op.pattern[0] && (op.pos_x[0] ^ op.pos_y[0])) ||
                 (op.pattern[1] && (op.pos_x[0] | op.pos_y[0]));
         if (!gated && x >= 0 && y >= 0 && x < clip_width && y < clip_height &&
             x < int'(PHYS_HEIGHT) && y < int'(PHYS_WIDTH)) begin
            idx = (PHYS_HEIGHT - 1 - x) * ROW_BYTES + y / 8;
            mask = PIXEL_MSB >> (y % 8);
            cur = frame_copy[idx];
            case (op.func)
               FUNC_BLACK: cur = cur & ~mask;
               FUNC_WHITE: cur = cur | mask;
               default:    cur = cur ^ mask;
            endcase
            frame_copy[idx] = cur;
            res.read_data = cur;
            res.applied = 1'b1;
         end
      end else if (op.func == FUNC_RDBYTE) begin
         if (op.byte_address < STORE_DEPTH) begin
            res.read_data = frame_copy[op.byte_address];
            res.applied = 1'b1;
         end
      end else if (op.func == FUNC_WRBYTE) begin
         if (op.byte_address < STORE_DEPTH) begin
            frame_copy[op.byte_address] = op.write_data;
            written[op.byte_address] = 1'b1;
            res.read_data = op.write_data;
            res.applied = 1'b1;
         end
      end
      return res;
   endfunction

   // Store byte that an operation reads, or -1 when it reads none.
   function automatic int read_index(plot_op_type op);
      int x;
      int y;
      logic gated;
      x = $signed(op.pos_x);
      y = $signed(op.pos_y);
      if (op.func == FUNC_BLACK || op.func == FUNC_WHITE || op.func == FUNC_INVERT) begin
         gated = (op.pattern[0] && (op.pos_x[0] ^ op.pos_y[0])) ||
                 (op.pattern[1] && (op.pos_x[0] | op.pos_y[0]));
         if (!gated && x >= 0 && y >= 0 && x < clip_width && y < clip_height &&
             x < int'(PHYS_HEIGHT) && y < int'(PHYS_WIDTH))
            return int'((PHYS_HEIGHT - 1 - x) * ROW_BYTES + y / 8);
      end else if (op.func == FUNC_RDBYTE && op.byte_address < STORE_DEPTH) begin
         return int'(op.byte_address);
      end
      return -1;
   endfunction

   function automatic plot_op_type pixel_op(logic [FUNC_W-1:0] func, int x, int y,
                                            logic [PAT_W-1:0] pattern);
      plot_op_type op;
      op.func = func;
      op.pos_x = COORD_W'(x);
      op.pos_y = COORD_W'(y);
      op.pattern = pattern;
      op.byte_address = BADDR_W'($urandom);
      op.write_data = BYTE_W'($urandom);
      return op;
   endfunction

   function automatic plot_op_type byte_op(logic [FUNC_W-1:0] func, int unsigned addr,
                                           logic [BYTE_W-1:0] data);
      plot_op_type op;
      op.func = func;
      op.pos_x = COORD_W'($urandom);
      op.pos_y = COORD_W'($urandom);
      op.pattern = PAT_W'($urandom);
      op.byte_address = BADDR_W'(addr);
      op.write_data = data;
      return op;
   endfunction

   // Sends one request; the prediction is queued at the accepting edge.
   task automatic send_op(input plot_op_type op);
      int gap;
      int rd_idx;
      rd_idx = read_index(op);
      if (rd_idx >= 0 && !written[rd_idx])
         send_op(byte_op(FUNC_WRBYTE, rd_idx, BYTE_W'($urandom)));
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.func <= op.func;
      req_chan.pos_x <= op.pos_x;
      req_chan.pos_y <= op.pos_y;
      req_chan.pattern <= op.pattern;
      req_chan.byte_address <= op.byte_address;
      req_chan.write_data <= op.write_data;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      awaited_results.push_back(framebuffer_result(op));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_clip(input logic reg_sel, input logic [CFG_W-1:0] value);
      logic [APB_DW-1:0] word;
      word = $urandom;
      word[CFG_W-1:0] = value;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= word;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_sel == REG_LWIDTH) clip_width = value;
      else clip_height = value;
      // Read the register straight back.
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {{(APB_DW-CFG_W){1'b0}}, value}) begin
         $display("%0t: register readback mismatch at %h, expected %h, got %h",
                  $time, {reg_sel, 2'b00}, value, prdata);
         fail_count++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_clip(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_clip(REG_LWIDTH, width);
      write_clip(REG_LHEIGHT, height);
   endtask

   task automatic test_directed_edges();
      idle_enable = 1'b1;
      send_op(byte_op(FUNC_WRBYTE, 0, 8'h00));
      send_op(byte_op(FUNC_RDBYTE, 0, 8'h00));
      send_op(byte_op(FUNC_WRBYTE, STORE_DEPTH - 1, 8'hFF));
      send_op(byte_op(FUNC_WRBYTE, STORE_DEPTH, 8'h5A));
      send_op(byte_op(FUNC_RDBYTE, STORE_DEPTH - 1, 8'h00));
      send_op(byte_op(FUNC_RDBYTE, STORE_DEPTH, 8'h00));
      send_op(byte_op(FUNC_WRBYTE, 16'hFFFF, 8'hA5));
      send_op(byte_op(FUNC_RDBYTE, 16'hFFFF, 8'h00));
      // Consecutive changes to one byte check that each write-back lands before the next read.
      send_op(pixel_op(FUNC_WHITE, 0, 0, PAT_NONE));
      send_op(pixel_op(FUNC_BLACK, 0, 1, PAT_NONE));
      send_op(pixel_op(FUNC_INVERT, 0, 7, PAT_NONE));
      send_op(pixel_op(FUNC_WHITE, 527, 791, PAT_NONE));
      send_op(pixel_op(FUNC_WHITE, 528, 0, PAT_NONE));
      send_op(pixel_op(FUNC_WHITE, 0, 792, PAT_NONE));
      send_op(pixel_op(FUNC_INVERT, -2048, 2047, PAT_NONE));
      send_op(pixel_op(FUNC_INVERT, 2047, -2048, PAT_NONE));
      send_op(pixel_op(FUNC_WHITE, -1, -1, PAT_CHECKER));
      send_op(pixel_op(FUNC_INVERT, 1, 2, PAT_CHECKER));
      send_op(pixel_op(FUNC_INVERT, 1, 1, PAT_CHECKER));
      send_op(pixel_op(FUNC_INVERT, 2, 1, PAT_QUARTER));
      send_op(pixel_op(FUNC_INVERT, 2, 4, PAT_QUARTER));
      send_op(pixel_op(FUNC_INVERT, 3, 1, PAT_BOTH));
      send_op(pixel_op(FUNC_INVERT, 4, 6, PAT_BOTH));
      for (int f = FUNC_UNUSED_FIRST; f <= FUNC_UNUSED_LAST; f++)
         send_op(pixel_op(FUNC_W'(f), 5, 5, PAT_NONE));
   endtask

   task automatic test_clip_registers();
      set_clip(CLIP_MAX, CLIP_MAX);
      send_op(pixel_op(FUNC_WHITE, 600, 10, PAT_NONE));
      send_op(pixel_op(FUNC_WHITE, 10, 900, PAT_NONE));
      send_op(pixel_op(FUNC_INVERT, 527, 791, PAT_NONE));
      set_clip(10'd0, 10'd0);
      send_op(pixel_op(FUNC_WHITE, 0, 0, PAT_NONE));
      send_op(byte_op(FUNC_RDBYTE, 0, 8'h00));
      set_clip(10'd1, 10'd1);
      send_op(pixel_op(FUNC_INVERT, 0, 0, PAT_NONE));
      send_op(pixel_op(FUNC_INVERT, 1, 0, PAT_NONE));
      send_op(pixel_op(FUNC_INVERT, 0, 1, PAT_NONE));
   endtask

   task automatic test_random_ops(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            win_x = $urandom_range(0, PHYS_HEIGHT - 4);
            win_y = 8 * $urandom_range(0, ROW_BYTES - 2);
         end
         if (n % 100 == 0) idle_enable = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 59) == 0) drain_results();
         pick = $urandom_range(0, 99);
         if (pick < 55)
            send_op(pixel_op(FUNC_W'($urandom_range(FUNC_BLACK, FUNC_INVERT)),
                             win_x + $urandom_range(0, 3), win_y + $urandom_range(0, 15),
                             PAT_W'($urandom_range(PAT_NONE, PAT_BOTH))));
         else if (pick < 70)
            send_op(pixel_op(FUNC_W'($urandom_range(FUNC_BLACK, FUNC_INVERT)),
                             $urandom_range(0, 560), $urandom_range(0, 830),
                             PAT_W'($urandom_range(PAT_NONE, PAT_BOTH))));
         else if (pick < 75)
            send_op(byte_op(FUNC_W'($urandom_range(FUNC_RDBYTE, FUNC_WRBYTE)),
                            (PHYS_HEIGHT - 1 - win_x) * ROW_BYTES + win_y / 8,
                            BYTE_W'($urandom)));
         else if (pick < 82)
            send_op(byte_op(FUNC_W'($urandom_range(FUNC_RDBYTE, FUNC_WRBYTE)),
                            $urandom_range(0, STORE_DEPTH - 1), BYTE_W'($urandom)));
         else if (pick < 92)
            send_op(pixel_op(FUNC_W'($urandom), $signed(COORD_W'($urandom)),
                             $signed(COORD_W'($urandom)), PAT_W'($urandom)));
         else
            send_op(byte_op(FUNC_W'($urandom_range(FUNC_RDBYTE, FUNC_WRBYTE)),
                            BADDR_W'($urandom), BYTE_W'($urandom)));
      end
   endtask

   task automatic test_random_regimes();
      set_clip(LOGICAL_WIDTH_RST, LOGICAL_HEIGHT_RST);
      test_random_ops(150);
      set_clip(CLIP_MAX, CLIP_MAX);
      test_random_ops(120);
      set_clip(CFG_W'($urandom), CFG_W'($urandom));
      test_random_ops(120);
      set_clip(10'd0, 10'd0);
      test_random_ops(60);
      set_clip(CFG_W'($urandom_range(100, 600)), CFG_W'($urandom_range(100, 900)));
      test_random_ops(150);
   endtask

   initial begin
      reset = 1'b1;
      fail_count = 0;
      idle_enable = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_BLACK;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.pattern = PAT_NONE;
      req_chan.byte_address = '0;
      req_chan.write_data = '0;
      clip_width = LOGICAL_WIDTH_RST;
      clip_height = LOGICAL_HEIGHT_RST;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_clip_registers();
      test_random_regimes();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/rfpp_pkg.sv
sv/rfpp_if.sv
sv/rfpp_csr.sv
sv/rfpp_store.sv
sv/rotated_framebuffer_pixel_plotter.sv
tb/sv/tb.sv
